// ----- rtl/lrct_pkg.sv -----
// Package for the learned remote code table: field widths, opcodes,
// sequencer states and the divide-by-five reciprocal.
// No dependencies.
`default_nettype none

package lrct_pkg;

   localparam int FUNC_W  = 2;
   localparam int CHAN_W  = 2;
   localparam int CODE_W  = 24;
   localparam int PULSE_W = 16;
   localparam int MASK_W  = 3;
   localparam int ENTRY_W = CODE_W + PULSE_W;

   // t / 5 == (t * 52429) >> 18, exact for every 16-bit t
   localparam logic [PULSE_W-1:0] DIV5_RECIP = 16'd52429;
   localparam int DIV5_SHIFT = 18;
   localparam int PROD_W = 2 * PULSE_W;
   localparam int TOL_W  = PROD_W - DIV5_SHIFT;

   localparam logic [FUNC_W-1:0] FUNC_LEARN = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/lrct_if.sv -----
// Valid/ready channels for the learned remote code table.
// Depends on lrct_pkg for the payload widths.
`default_nettype none

interface lrct_req_if
   import lrct_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [CHAN_W-1:0]    channel;
   logic [CODE_W-1:0]    code_word;
   logic [PULSE_W-1:0]   pulse_time;

   modport source (output valid, func, channel, code_word, pulse_time, input ready);
   modport sink   (input valid, func, channel, code_word, pulse_time, output ready);
endinterface

interface lrct_rsp_if
   import lrct_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [MASK_W-1:0]    match_mask;
   logic                 stored;

   modport source (output valid, match_mask, stored, input ready);
   modport sink   (input valid, match_mask, stored, output ready);
endinterface

`default_nettype wire

// ----- rtl/learned_remote_code_table.sv -----
// Top level of the learned remote code table: per-channel code rings,
// slot scanner with a compare unit per channel, learn and clear.
// Depends on lrct_pkg and the channel interfaces in lrct_if.
`default_nettype none

// Usage
// -----
// req_port carries one item per valid/ready handshake: func (match, learn,
// clear), channel, code_word and pulse_time. rsp_port returns exactly one
// item per request: match_mask (bit per channel that held a matching entry
// before any update) and stored (learn wrote a new entry).
// Each channel keeps a ring of ENTRIES_PER_CHANNEL entries in its own RAM.
// The sequencer walks the slots one per cycle, all channels in parallel,
// through a three-stage compare path (RAM read, tolerance multiply by the
// reciprocal of five, window compare).
// An item is accepted only once the previous one has left the sequencer;
// its slot scan occupies the single RAM read port per channel.
// req ready is high only while the sequencer is idle.
// Reset clears the ring counts, so every channel starts empty; the RAM
// contents are not cleared, and an entry is never used before being written.
// A result sits in the output register until taken; if the sink stalls,
// the next item may still be accepted and scanned, and it waits for the
// output register to free before its result is loaded.
module learned_remote_code_table_core
   import lrct_pkg::*;
#(
   parameter int ENTRIES_PER_CHANNEL = 14,
   parameter int CHANNELS            = 3
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lrct_req_if.sink    req_port,
   lrct_rsp_if.source  rsp_port
);

   localparam int AW   = (ENTRIES_PER_CHANNEL > 1) ? $clog2(ENTRIES_PER_CHANNEL) : 1;
   localparam int SW   = $clog2(ENTRIES_PER_CHANNEL + 1);
   localparam int CNTW = $clog2(2 * ENTRIES_PER_CHANNEL + 1);
   localparam int SELW = 3;   // wide enough to name every channel index

   localparam logic [CNTW-1:0] EPC_C   = CNTW'(ENTRIES_PER_CHANNEL);
   localparam logic [CNTW-1:0] WRAP_C  = CNTW'(2 * ENTRIES_PER_CHANNEL);
   localparam logic [SW-1:0]   LAST_SL = SW'(ENTRIES_PER_CHANNEL - 1);

   // sequencer
   state_type state_ff, state_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic req_fire, out_free;

   // captured item
   logic [FUNC_W-1:0]  func_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [PULSE_W-1:0] pulse_ff;

   // compare pipeline
   logic                s1_v_ff, s2_v_ff;
   logic [CHANNELS-1:0] lim1_ff, lim1_in;
   logic [CHANNELS-1:0] eq2_ff, eq2_in;
   logic [CHANNELS-1:0] hit_ff, hit2;
   logic [ENTRY_W-1:0]  rd_ff  [CHANNELS];
   logic [PULSE_W-1:0]  t2_ff  [CHANNELS];
   logic [TOL_W-1:0]    tol2_ff[CHANNELS];
   logic [TOL_W-1:0]    tol1   [CHANNELS];

   // ring state
   logic [CNTW-1:0]     count_ff[CHANNELS];
   logic [CNTW-1:0]     count_in[CHANNELS];
   logic [AW-1:0]       wr_addr [CHANNELS];
   logic [CHANNELS-1:0] wr_en, learn_sel, clear_sel;
   logic [AW-1:0]       rd_addr;
   logic [ENTRY_W-1:0]  wr_data;

   // result
   logic              stored_ff, stored_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] rsp_mask_ff, mask_now;
   logic              rsp_stored_ff;

   assign req_fire = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign rd_addr  = slot_ff[AW-1:0];
   assign wr_data  = {code_ff, pulse_ff};

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_port.valid) state_in = ST_SCAN;
         ST_SCAN:   if (slot_ff == LAST_SL) state_in = ST_DRAIN;
         ST_DRAIN:  if (!s1_v_ff && !s2_v_ff) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_RESP;
         ST_RESP:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_port.ready = 1'b0;
      slot_in        = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_port.ready = 1'b1;
            slot_in        = '0;
         end
         ST_SCAN:   slot_in = slot_ff + SW'(1);
         ST_DRAIN,
         ST_COMMIT,
         ST_RESP:   slot_in = slot_ff;
         default:   slot_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         s1_v_ff  <= (state_ff == ST_SCAN);
         s2_v_ff  <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_port.func;
         chan_ff  <= req_port.channel;
         code_ff  <= req_port.code_word;
         pulse_ff <= req_port.pulse_time;
      end
   end

   // ---------------- per-channel ring and compare unit ----------------
   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      logic [ENTRY_W-1:0] mem [ENTRIES_PER_CHANNEL];
      logic [CNTW-1:0]    lim, v_adj, slot_w;
      logic [PROD_W-1:0]  prod;
      logic [PULSE_W:0]   hi_bound;
      logic [PULSE_W-1:0] lo_bound;
      logic               sel;

      // valid slots are 0 .. min(count, depth) - 1
      assign lim        = (count_ff[c] > EPC_C) ? EPC_C : count_ff[c];
      assign lim1_in[c] = CNTW'(slot_ff) < lim;

      always_ff @(posedge clock) begin
         if (wr_en[c]) mem[wr_addr[c]] <= wr_data;
         rd_ff[c] <= mem[rd_addr];
      end

      // stage 1: code compare, T/5 by reciprocal multiply
      assign prod      = PROD_W'(rd_ff[c][PULSE_W-1:0]) * PROD_W'(DIV5_RECIP);
      assign tol1[c]   = prod[PROD_W-1:DIV5_SHIFT];
      assign eq2_in[c] = lim1_ff[c] && (rd_ff[c][ENTRY_W-1:PULSE_W] == code_ff);

      always_ff @(posedge clock) begin
         lim1_ff[c] <= lim1_in[c];
         eq2_ff[c]  <= eq2_in[c];
         t2_ff[c]   <= rd_ff[c][PULSE_W-1:0];
         tol2_ff[c] <= tol1[c];
      end

      // stage 2: open window T - T/5 < P < T + T/5, upper sum kept 17 bits
      assign hi_bound = (PULSE_W+1)'(t2_ff[c]) + (PULSE_W+1)'(tol2_ff[c]);
      assign lo_bound = t2_ff[c] - PULSE_W'(tol2_ff[c]);
      assign hit2[c]  = eq2_ff[c] && ((PULSE_W+1)'(pulse_ff) < hi_bound)
                        && (pulse_ff > lo_bound);

      // ring update: fold the count back by one ring once it reaches 2x depth
      assign sel          = ({1'b0, chan_ff} == SELW'(c));
      assign learn_sel[c] = (func_ff == FUNC_LEARN) && sel && !hit_ff[c];
      assign clear_sel[c] = (func_ff == FUNC_CLEAR) && sel;
      assign v_adj        = (count_ff[c] >= WRAP_C) ? count_ff[c] - EPC_C : count_ff[c];
      assign slot_w       = (v_adj >= EPC_C) ? v_adj - EPC_C : v_adj;
      assign wr_addr[c]   = slot_w[AW-1:0];
      assign wr_en[c]     = (state_ff == ST_COMMIT) && learn_sel[c];

      always_comb begin
         count_in[c] = count_ff[c];
         if (state_ff == ST_COMMIT) begin
            priority if (learn_sel[c]) count_in[c] = v_adj + CNTW'(1);
            else if (clear_sel[c])     count_in[c] = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) count_ff[c] <= '0;
         else       count_ff[c] <= count_in[c];
      end
   end

   // hit vector: cleared per item, collects the compare stage
   always_ff @(posedge clock) begin
      if (req_fire)     hit_ff <= '0;
      else if (s2_v_ff) hit_ff <= hit_ff | hit2;
   end

   // ---------------- result ----------------
   for (genvar i = 0; i < MASK_W; i++) begin : g_mask
      if (i < CHANNELS) begin : g_on
         assign mask_now[i] = hit_ff[i];
      end else begin : g_off
         assign mask_now[i] = 1'b0;
      end
   end

   assign stored_in = (state_ff == ST_COMMIT) ? |learn_sel : stored_ff;

   always_ff @(posedge clock) begin
      stored_ff <= stored_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      if (state_ff == ST_RESP && out_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RESP && out_free) begin
         rsp_mask_ff   <= mask_now;
         rsp_stored_ff <= stored_ff;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.match_mask = rsp_mask_ff;
   assign rsp_port.stored     = rsp_stored_ff;

   // ---------------- checks ----------------
   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> (!s1_v_ff && !s2_v_ff))
      else $error("ring update with compare pipeline still busy");

   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> (state_ff == ST_RESP))
      else $error("ring update not followed by result stage");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_en))
      else $error("learn wrote more than one channel");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> $past(s1_v_ff))
      else $error("compare stage without a preceding read");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= WRAP_C)
      else $error("ring count beyond twice the depth");

endmodule

`default_nettype wire
